### src/pacb_pkg.sv
// ----------------------------------------------------------------------------
// pacb_pkg
// Shared widths, defaults, queue and divider records, and state encodings
// for the polygon area, centroid and bounding box block.
// ----------------------------------------------------------------------------
package pacb_pkg;

   localparam int COORD_W          = 16;
   localparam int AREA_W           = 48;
   localparam int ABS_W            = 47;
   localparam int MOM_W            = 64;
   localparam int PROD_W           = 2 * COORD_W;
   localparam int EDGE_W           = PROD_W + 1;
   localparam int SUM_W            = COORD_W + 1;
   localparam int MX_W             = SUM_W + EDGE_W;
   localparam int DEN_W            = AREA_W + 2;
   localparam int DMAG_W           = AREA_W + 1;
   localparam int QUO_W            = 16;
   localparam int STEP_W           = 4;
   localparam int VCOUNT_W         = 13;
   localparam int REQ_TDATA_W      = 2 * COORD_W;
   localparam int RSP_PAD_W        = 2;
   localparam int RSP_TDATA_W      = 208;
   localparam int RSP_TUSER_W      = 1;
   localparam int MAX_VERTICES_DEF = 4096;
   localparam int QUEUE_DEPTH_DEF  = 4;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type             min_x;
      coord_type             min_y;
      logic [COORD_W-1:0]    box_w;
      logic [COORD_W-1:0]    box_h;
      logic [VCOUNT_W-1:0]   vcount;
      logic                  too_many;
   } pacb_sum_type;

   typedef struct packed {
      coord_type    ax;
      coord_type    ay;
      coord_type    bx;
      coord_type    by;
      logic         close;
      pacb_sum_type sum;
   } pacb_edge_type;

   typedef struct packed {
      logic          push;
      pacb_edge_type entry;
   } pacb_push_type;

   typedef struct packed {
      logic                    start;
      logic signed [MOM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } pacb_div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [QUO_W-1:0] quo;
   } pacb_div_rsp_type;

   typedef enum logic {
      FR_RUN,
      FR_CLOSE
   } pacb_front_state_type;

   typedef enum logic [2:0] {
      BK_RUN,
      BK_DRAIN,
      BK_STX,
      BK_WX,
      BK_STY,
      BK_WY,
      BK_LOAD
   } pacb_back_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_CHECK,
      DV_STEP,
      DV_DONE
   } pacb_div_state_type;

endpackage

### src/pacb_front.sv
// ----------------------------------------------------------------------------
// pacb_front
// Vertex intake: keeps first and previous vertex, vertex count, overflow and
// bounding box, and turns each later vertex into an edge for the back end. After
// the final vertex, the close state issues the closing edge with summary.
// ----------------------------------------------------------------------------
module pacb_front import pacb_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   q_full,
   output pacb_push_type          push
);

   localparam int               CNT_W   = $clog2(MAX_VERTICES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

   pacb_front_state_type state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 over_ff, over_in;
   coord_type            first_x_ff, first_x_in, first_y_ff, first_y_in;
   coord_type            prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type            lo_x_ff, lo_x_in, lo_y_ff, lo_y_in;
   coord_type            hi_x_ff, hi_x_in, hi_y_ff, hi_y_in;

   coord_type                     x, y;
   logic                          fire;
   logic [CNT_W+VCOUNT_W-1:0]     vc_wide;

   assign x       = req_tdata[COORD_W-1:0];
   assign y       = req_tdata[2*COORD_W-1:COORD_W];
   assign vc_wide = {{VCOUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_RUN;
         count_ff <= '0;
         over_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         over_ff  <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
      lo_x_ff    <= lo_x_in;
      lo_y_ff    <= lo_y_in;
      hi_x_ff    <= hi_x_in;
      hi_y_ff    <= hi_y_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      over_in    = over_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      lo_x_in    = lo_x_ff;
      lo_y_in    = lo_y_ff;
      hi_x_in    = hi_x_ff;
      hi_y_in    = hi_y_ff;
      req_tready = 1'b0;
      fire       = 1'b0;
      push       = '0;
      push.entry.ax = prev_x_ff;
      push.entry.ay = prev_y_ff;
      push.entry.bx = x;
      push.entry.by = y;
      case (state_ff)
         FR_RUN: begin
            req_tready = !q_full;
            fire       = req_tvalid && req_tready;
            if (fire) begin
               if (count_ff != CNT_MAX) begin
                  if (count_ff == '0) begin
                     first_x_in = x;
                     first_y_in = y;
                     lo_x_in    = x;
                     hi_x_in    = x;
                     lo_y_in    = y;
                     hi_y_in    = y;
                  end else begin
                     push.push = 1'b1;
                     if (x < lo_x_ff) lo_x_in = x;
                     if (x > hi_x_ff) hi_x_in = x;
                     if (y < lo_y_ff) lo_y_in = y;
                     if (y > hi_y_ff) hi_y_in = y;
                  end
                  prev_x_in = x;
                  prev_y_in = y;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  over_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = FR_CLOSE;
               end
            end
         end
         FR_CLOSE: begin
            push.entry.bx           = first_x_ff;
            push.entry.by           = first_y_ff;
            push.entry.close        = 1'b1;
            push.entry.sum.min_x    = lo_x_ff;
            push.entry.sum.min_y    = lo_y_ff;
            push.entry.sum.box_w    = $unsigned(hi_x_ff - lo_x_ff);
            push.entry.sum.box_h    = $unsigned(hi_y_ff - lo_y_ff);
            push.entry.sum.vcount   = vc_wide[VCOUNT_W-1:0];
            push.entry.sum.too_many = over_ff;
            if (!q_full) begin
               push.push = 1'b1;
               count_in  = '0;
               over_in   = 1'b0;
               state_in  = FR_RUN;
            end
         end
         default: begin
            state_in = FR_RUN;
         end
      endcase
   end

endmodule

### src/pacb_queue.sv
// ----------------------------------------------------------------------------
// pacb_queue
// Edge queue between intake and arithmetic; head entry is shown directly.
// ----------------------------------------------------------------------------
module pacb_queue import pacb_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  pacb_push_type push,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output pacb_edge_type head
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   pacb_edge_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full    = fill_ff == FILL_W'(DEPTH);
   assign empty   = fill_ff == '0;
   assign do_push = push.push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

### src/pacb_div.sv
// ----------------------------------------------------------------------------
// pacb_div
// Saturating signed divider for the centroid: magnitude, overflow check
// against the 16-bit quotient range, then one restoring step per cycle.
// ----------------------------------------------------------------------------
module pacb_div import pacb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  pacb_div_req_type req,
   output pacb_div_rsp_type rsp
);

   localparam int DSH_W = DMAG_W + QUO_W - 1;

   localparam logic signed [QUO_W-1:0] QUO_MAX = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic signed [QUO_W-1:0] QUO_MIN = {1'b1, {(QUO_W-1){1'b0}}};

   pacb_div_state_type state_ff, state_in;
   logic [MOM_W-1:0]   rem_ff, rem_in;
   logic [DMAG_W-1:0]  dmag_ff, dmag_in;
   logic [DSH_W-1:0]   dsh_ff, dsh_in;
   logic [QUO_W-1:0]   q_ff, q_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               neg_ff, neg_in, sat_ff, sat_in;

   logic [MOM_W-1:0]   num_abs;
   logic [DEN_W-1:0]   den_abs;
   logic [MOM_W:0]     trial;

   assign num_abs = req.num[MOM_W-1] ? ~req.num + MOM_W'(1) : req.num;
   assign den_abs = req.den[DEN_W-1] ? ~req.den + DEN_W'(1) : req.den;
   assign trial   = {1'b0, rem_ff} - {1'b0, dsh_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dmag_in  = dmag_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      sat_in   = sat_ff;
      rsp      = '0;
      case (state_ff)
         DV_IDLE: begin
            if (req.start) begin
               rem_in   = num_abs;
               dmag_in  = den_abs[DMAG_W-1:0];
               neg_in   = req.num[MOM_W-1] ^ req.den[DEN_W-1];
               state_in = DV_CHECK;
            end
         end
         DV_CHECK: begin
            sat_in  = {1'b0, rem_ff[MOM_W-1:QUO_W]} >= dmag_ff;
            dsh_in  = {dmag_ff, {(QUO_W-1){1'b0}}};
            q_in    = '0;
            step_in = STEP_W'(QUO_W - 1);
            state_in = sat_in ? DV_DONE : DV_STEP;
         end
         DV_STEP: begin
            if (!trial[MOM_W]) begin
               rem_in = trial[MOM_W-1:0];
               q_in   = {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               q_in   = {q_ff[QUO_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) begin
               state_in = DV_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         DV_DONE: begin
            rsp.done = 1'b1;
            if (sat_ff) begin
               rsp.quo = neg_ff ? QUO_MIN : QUO_MAX;
            end else if (neg_ff) begin
               rsp.quo = (q_ff > QUO_MIN) ? QUO_MIN : $signed(~q_ff + QUO_W'(1));
            end else begin
               rsp.quo = q_ff[QUO_W-1] ? QUO_MAX : $signed(q_ff);
            end
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

endmodule

### src/pacb_back.sv
// ----------------------------------------------------------------------------
// pacb_back
// Edge arithmetic: pipelined cross term and moment accumulation, then per
// polygon the two centroid divisions, skipped for zero area, and the result register.
// ----------------------------------------------------------------------------
module pacb_back import pacb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   empty,
   input  pacb_edge_type          head,
   output logic                   pop,
   output pacb_div_req_type       div_req,
   input  pacb_div_rsp_type       div_rsp,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   pacb_back_state_type state_ff, state_in;

   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   logic signed [SUM_W-1:0]  sx_a_ff, sy_a_ff, sx_b_ff, sy_b_ff;
   logic signed [EDGE_W-1:0] f_ff;
   logic signed [MX_W-1:0]   mx_ff, my_ff;
   logic                     va_ff, vb_ff, vc_ff;
   logic                     close_a_ff, close_b_ff, close_c_ff, close_d_ff;

   logic signed [AREA_W-1:0] area_ff, res_area_ff;
   logic signed [MOM_W-1:0]  mom_x_ff, mom_y_ff, num_x_ff, num_y_ff;
   logic signed [DEN_W-1:0]  den_ff;
   logic signed [QUO_W-1:0]  cx_ff, cy_ff;
   pacb_sum_type             sum_ff;

   logic                     rsp_tvalid_ff;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0]   rsp_tuser_ff;

   logic                     capture, take_x, take_y, load_out;
   logic                     neg, degen;
   logic [AREA_W-1:0]        mag;
   logic [ABS_W-1:0]         abs_area;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      capture  = 1'b0;
      take_x   = 1'b0;
      take_y   = 1'b0;
      load_out = 1'b0;
      div_req  = '0;
      div_req.num = num_x_ff;
      div_req.den = den_ff;
      case (state_ff)
         BK_RUN: begin
            pop = !empty;
            if (pop && head.close) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (close_d_ff) begin
               capture  = 1'b1;
               state_in = (area_ff == '0) ? BK_LOAD : BK_STX;
            end
         end
         BK_STX: begin
            div_req.start = 1'b1;
            state_in      = BK_WX;
         end
         BK_WX: begin
            if (div_rsp.done) begin
               take_x   = 1'b1;
               state_in = BK_STY;
            end
         end
         BK_STY: begin
            div_req.start = 1'b1;
            div_req.num   = num_y_ff;
            state_in      = BK_WY;
         end
         BK_WY: begin
            div_req.num = num_y_ff;
            if (div_rsp.done) begin
               take_y   = 1'b1;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_RUN;
         va_ff      <= 1'b0;
         vb_ff      <= 1'b0;
         vc_ff      <= 1'b0;
         close_a_ff <= 1'b0;
         close_b_ff <= 1'b0;
         close_c_ff <= 1'b0;
         close_d_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         va_ff      <= pop;
         vb_ff      <= va_ff;
         vc_ff      <= vb_ff;
         close_a_ff <= pop && head.close;
         close_b_ff <= va_ff && close_a_ff;
         close_c_ff <= vb_ff && close_b_ff;
         close_d_ff <= vc_ff && close_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff   <= PROD_W'(head.ax) * PROD_W'(head.by);
      p2_ff   <= PROD_W'(head.bx) * PROD_W'(head.ay);
      sx_a_ff <= SUM_W'(head.ax) + SUM_W'(head.bx);
      sy_a_ff <= SUM_W'(head.ay) + SUM_W'(head.by);
      f_ff    <= EDGE_W'(p1_ff) - EDGE_W'(p2_ff);
      sx_b_ff <= sx_a_ff;
      sy_b_ff <= sy_a_ff;
      mx_ff   <= MX_W'(sx_b_ff) * MX_W'(f_ff);
      my_ff   <= MX_W'(sy_b_ff) * MX_W'(f_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff  <= '0;
         mom_x_ff <= '0;
         mom_y_ff <= '0;
      end else if (capture) begin
         area_ff  <= '0;
         mom_x_ff <= '0;
         mom_y_ff <= '0;
      end else begin
         if (vb_ff) begin
            area_ff <= area_ff + AREA_W'(f_ff);
         end
         if (vc_ff) begin
            mom_x_ff <= mom_x_ff + MOM_W'(mx_ff);
            mom_y_ff <= mom_y_ff + MOM_W'(my_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.close) begin
         sum_ff <= head.sum;
      end
      if (capture) begin
         res_area_ff <= area_ff;
         num_x_ff    <= mom_x_ff;
         num_y_ff    <= mom_y_ff;
         den_ff      <= DEN_W'(area_ff) + (DEN_W'(area_ff) <<< 1);
         cx_ff       <= '0;
         cy_ff       <= '0;
      end
      if (take_x) begin
         cx_ff <= div_rsp.quo;
      end
      if (take_y) begin
         cy_ff <= div_rsp.quo;
      end
   end

   assign neg      = res_area_ff[AREA_W-1];
   assign degen    = res_area_ff == '0;
   assign mag      = neg ? ~res_area_ff + AREA_W'(1) : res_area_ff;
   assign abs_area = mag[AREA_W-1] ? {ABS_W{1'b1}} : mag[ABS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, sum_ff.vcount, sum_ff.box_h, sum_ff.box_w,
                          sum_ff.min_y, sum_ff.min_x, degen, cy_ff, cx_ff, neg,
                          abs_area, res_area_ff};
         rsp_tuser_ff <= sum_ff.too_many;
      end
   end

endmodule

### src/polygon_area_centroid_bounds_top.sv
// ----------------------------------------------------------------------------
// polygon_area_centroid_bounds_top
// Shoelace polygon measure: twice signed and absolute area, orientation,
// centroid and bounding box of a polygon streamed one vertex per transfer.
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata {y, x}, tlast = final vertex
//   rsp      out  rsp_tvalid/tready    tdata result fields, tuser too_many
//
// After the final vertex the intake stalls in a close state that issues the
// closing edge into the QUEUE_DEPTH-entry edge queue.
// After popping its closing edge the back end runs, per polygon, a 4-stage
// multiply-accumulate drain and, for nonzero area, two 16-step centroid
// divisions on one shared divider. Intake also stalls when the edge queue is full.
// Reset is synchronous, active high; no clearing pass is needed.
// ----------------------------------------------------------------------------
module polygon_area_centroid_bounds_top import pacb_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // x [15:0], y [31:16]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // twice_signed_area [47:0], twice_abs_area [94:48], clockwise [95],
   // centroid_x [111:96], centroid_y [127:112], degenerate [128],
   // min_x [144:129], min_y [160:145], box_width [176:161],
   // box_height [192:177], vertex_count [205:193], zero [207:206]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // too_many [0]
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   pacb_push_type    push;
   pacb_edge_type    head;
   pacb_div_req_type div_req;
   pacb_div_rsp_type div_rsp;
   logic             q_full, q_empty, pop;

   pacb_front #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   pacb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (pop),
      .empty (q_empty),
      .head  (head)
   );

   pacb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pacb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head       (head),
      .pop        (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### src/pacb_checker.sv
// ----------------------------------------------------------------------------
// pacb_checker
// Port-level checks on the result stream, attached to the top level.
// ----------------------------------------------------------------------------
module pacb_checker import pacb_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int CW_BIT    = 95;
   localparam int DEGEN_BIT = 128;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_orientation: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[CW_BIT] == rsp_tdata[AREA_W-1])
      else $error("clockwise flag disagrees with area sign");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[DEGEN_BIT] |->
         rsp_tdata[AREA_W-1:0] == '0 && rsp_tdata[127:96] == '0)
      else $error("degenerate result with area or centroid set");

   a_abs_area: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[CW_BIT] |-> rsp_tdata[94:48] == rsp_tdata[ABS_W-1:0])
      else $error("absolute area differs from positive signed area");

endmodule

bind polygon_area_centroid_bounds_top pacb_checker u_pacb_checker (.*);

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polygon_area_centroid_bounds_top. Polygons stream
// in one vertex per transfer with random gaps. An in-bench shoelace
// predictor folds every accepted vertex and queues one expected measure per
// final vertex. Each result transfer is checked field by field against the
// oldest queued measure.
// ----------------------------------------------------------------------------
module testbench import pacb_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 200;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_SMALL,
      SPREAD_EDGE,
      SPREAD_CLUSTER
   } coord_style_type;

   typedef struct {
      coord_type x;
      coord_type y;
      logic      last;
      logic      drain_first;
   } vertex_type;

   typedef struct {
      logic signed [AREA_W-1:0] twice_area;
      logic [ABS_W-1:0]         twice_abs;
      logic                     clockwise;
      coord_type                centroid_x;
      coord_type                centroid_y;
      logic                     degenerate;
      coord_type                min_x;
      coord_type                min_y;
      logic [COORD_W-1:0]       box_width;
      logic [COORD_W-1:0]       box_height;
      logic [VCOUNT_W-1:0]      vertex_count;
      logic                     too_many;
   } measure_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   vertex_type  vertex_queue[$];
   measure_type measure_expect[$];
   vertex_type  sent_vertex;
   measure_type want;
   measure_type got;
   int          failures    = 0;
   int          cycle_count = 0;
   int          idle_left   = 0;
   int          stall_left  = 0;

   coord_type                first_x, first_y, prev_x, prev_y;
   coord_type                low_x, low_y, high_x, high_y;
   logic signed [AREA_W-1:0] area_acc;
   longint                   moment_x_acc, moment_y_acc;
   int                       vertex_total;
   logic                     overflow_seen;

   polygon_area_centroid_bounds_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int draw_gap();
      int r;
      if (cycle_count[10:9] == 2'b11) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void clear_polygon();
      first_x       = '0;
      first_y       = '0;
      prev_x        = '0;
      prev_y        = '0;
      low_x         = '0;
      low_y         = '0;
      high_x        = '0;
      high_y        = '0;
      area_acc      = '0;
      moment_x_acc  = 0;
      moment_y_acc  = 0;
      vertex_total  = 0;
      overflow_seen = 1'b0;
   endfunction

   function automatic void add_edge_terms(coord_type ax, coord_type ay,
                                          coord_type bx, coord_type by);
      longint fterm;
      fterm        = longint'(ax) * longint'(by) - longint'(bx) * longint'(ay);
      area_acc     = area_acc + fterm[AREA_W-1:0];
      moment_x_acc = moment_x_acc + (longint'(ax) + longint'(bx)) * fterm;
      moment_y_acc = moment_y_acc + (longint'(ay) + longint'(by)) * fterm;
   endfunction

   function automatic coord_type centroid_of(longint moment, longint twice_area);
      longint q;
      q = moment / (3 * twice_area);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return coord_type'(q);
   endfunction

   function automatic void fold_vertex(vertex_type v);
      measure_type m;
      longint      s;
      longint      mag;
      if (vertex_total < MAX_VERTICES_DEF) begin
         if (vertex_total == 0) begin
            first_x = v.x;
            first_y = v.y;
            low_x   = v.x;
            high_x  = v.x;
            low_y   = v.y;
            high_y  = v.y;
         end else begin
            add_edge_terms(prev_x, prev_y, v.x, v.y);
            if (v.x < low_x) low_x = v.x;
            if (v.x > high_x) high_x = v.x;
            if (v.y < low_y) low_y = v.y;
            if (v.y > high_y) high_y = v.y;
         end
         prev_x = v.x;
         prev_y = v.y;
         vertex_total++;
      end else begin
         overflow_seen = 1'b1;
      end
      if (!v.last) return;
      add_edge_terms(prev_x, prev_y, first_x, first_y);
      s = area_acc;
      mag = (s < 0) ? -s : s;
      if (mag > 64'sh7FFF_FFFF_FFFF) mag = 64'sh7FFF_FFFF_FFFF;
      m.twice_area   = area_acc;
      m.twice_abs    = mag[ABS_W-1:0];
      m.clockwise    = (s < 0);
      m.degenerate   = (s == 0);
      m.centroid_x   = (s == 0) ? coord_type'(0) : centroid_of(moment_x_acc, s);
      m.centroid_y   = (s == 0) ? coord_type'(0) : centroid_of(moment_y_acc, s);
      m.min_x        = low_x;
      m.min_y        = low_y;
      m.box_width    = high_x - low_x;
      m.box_height   = high_y - low_y;
      m.vertex_count = vertex_total[VCOUNT_W-1:0];
      m.too_many     = overflow_seen;
      measure_expect = {measure_expect, m};
      clear_polygon();
   endfunction

   function automatic void check_field(string name, logic [63:0] exp_v,
                                       logic [63:0] act_v);
      if (exp_v !== act_v) begin
         failures++;
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
   endfunction

   // drive vertices; fold each one into the predictor on its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_tvalid && req_tready) fold_vertex(sent_vertex);
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (vertex_queue.size() != 0 &&
                         !(vertex_queue[0].drain_first && measure_expect.size() != 0)) begin
               sent_vertex = vertex_queue.pop_front();
               req_tdata  <= {sent_vertex.y, sent_vertex.x};
               req_tlast  <= sent_vertex.last;
               req_tvalid <= 1'b1;
               idle_left = draw_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = draw_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.twice_area   = rsp_tdata[47:0];
         got.twice_abs    = rsp_tdata[94:48];
         got.clockwise    = rsp_tdata[95];
         got.centroid_x   = rsp_tdata[111:96];
         got.centroid_y   = rsp_tdata[127:112];
         got.degenerate   = rsp_tdata[128];
         got.min_x        = rsp_tdata[144:129];
         got.min_y        = rsp_tdata[160:145];
         got.box_width    = rsp_tdata[176:161];
         got.box_height   = rsp_tdata[192:177];
         got.vertex_count = rsp_tdata[205:193];
         got.too_many     = rsp_tuser[0];
         if (measure_expect.size() == 0) begin
            failures++;
            $display("%0t: result transfer expected none actual area %h",
                     $time, got.twice_area);
         end else begin
            want = measure_expect.pop_front();
            check_field("twice_signed_area", want.twice_area, got.twice_area);
            check_field("twice_abs_area", want.twice_abs, got.twice_abs);
            check_field("clockwise", want.clockwise, got.clockwise);
            check_field("centroid_x", want.centroid_x, got.centroid_x);
            check_field("centroid_y", want.centroid_y, got.centroid_y);
            check_field("degenerate", want.degenerate, got.degenerate);
            check_field("min_x", want.min_x, got.min_x);
            check_field("min_y", want.min_y, got.min_y);
            check_field("box_width", want.box_width, got.box_width);
            check_field("box_height", want.box_height, got.box_height);
            check_field("vertex_count", want.vertex_count, got.vertex_count);
            check_field("too_many", want.too_many, got.too_many);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("polygon_area_centroid_bounds_top: mismatch");
         $finish;
      end
   end

   function automatic void add_vertex(int x, int y, bit last, bit drain_first);
      vertex_type v;
      v.x           = coord_type'(x);
      v.y           = coord_type'(y);
      v.last        = last;
      v.drain_first = drain_first;
      vertex_queue  = {vertex_queue, v};
   endfunction

   function automatic int pick_coord(coord_style_type style);
      int edge_values[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      case (style)
         SPREAD_SMALL: return int'($urandom_range(0, 200)) - 100;
         SPREAD_EDGE:  return edge_values[$urandom_range(0, 6)];
         SPREAD_CLUSTER: begin
            if ($urandom_range(0, 1) == 0) return 32767 - int'($urandom_range(0, 15));
            return -32768 + int'($urandom_range(0, 15));
         end
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic void queue_polygon(int n, coord_style_type style, bit drain_first);
      for (int i = 0; i < n; i++)
         add_vertex(pick_coord(style), pick_coord(style), i == n - 1,
                    drain_first && i == 0);
   endfunction

   function automatic int queue_random_run(int target, int done_so_far);
      int total;
      int r;
      int n;
      total = done_so_far;
      while (total < target) begin
         r = $urandom_range(0, 99);
         if (r < 8) n = 1;
         else if (r < 16) n = 2;
         else if (r < 60) n = $urandom_range(3, 6);
         else if (r < 92) n = $urandom_range(7, 20);
         else n = $urandom_range(21, 64);
         queue_polygon(n, coord_style_type'($urandom_range(0, 3)),
                       $urandom_range(0, 14) == 0);
         total += n;
      end
      return total;
   endfunction

   initial begin
      int random_items;
      clear_polygon();

      add_vertex(-32768, 32767, 1, 0);
      add_vertex(5, -7, 0, 0);
      add_vertex(5, -7, 1, 0);
      add_vertex(0, 0, 0, 0);
      add_vertex(10, 0, 0, 0);
      add_vertex(0, 10, 1, 0);
      add_vertex(0, 0, 0, 0);
      add_vertex(0, 10, 0, 0);
      add_vertex(10, 0, 1, 0);
      add_vertex(-32768, -32768, 0, 0);
      add_vertex(32767, -32768, 0, 0);
      add_vertex(32767, 32767, 0, 0);
      add_vertex(-32768, 32767, 1, 0);
      add_vertex(1, 1, 0, 0);
      add_vertex(2, 2, 0, 0);
      add_vertex(3, 3, 1, 0);
      // crossed quads with small net area push the centroid out of range
      add_vertex(0, -1, 0, 0);
      add_vertex(0, 1, 0, 0);
      add_vertex(30000, -1, 0, 0);
      add_vertex(30000, 2, 1, 0);
      add_vertex(0, -1, 0, 0);
      add_vertex(0, 1, 0, 0);
      add_vertex(-30000, -1, 0, 0);
      add_vertex(-30000, 2, 1, 0);

      random_items = queue_random_run(340, 0);
      random_items = queue_random_run(680, random_items);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (vertex_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (measure_expect.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("polygon_area_centroid_bounds_top: match");
      end else begin
         $display("polygon_area_centroid_bounds_top: mismatch");
      end
      $finish;
   end

endmodule
